// File: sv/afss_pkg.sv
// ----------------------------------------------------------------------------
// afss_pkg
// Shared widths, constants, register codes and sideband types for the
// aspect fit scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package afss_pkg;

  localparam int DIM_W       = 14;
  localparam int GRAN_W      = 9;
  localparam int PCT_W       = 7;
  localparam int IDX_W       = 3;
  localparam int QW          = 2 * DIM_W;
  localparam int VW          = QW + 2;
  localparam int PROD_W      = 21;
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 28;
  localparam int MAX_DIM_DEF = 8192;
  localparam int DIV_BPS     = 4;

  localparam logic [PCT_W-1:0]   PCT_FULL = 7'd100;
  // ceil(2^28 / 100), exact floor for products below 2^21
  localparam logic [RECIP_W-1:0] RECIP    = 22'd2684355;

  typedef enum logic [IDX_W-1:0] {
    REG_MAX_WIDTH      = 3'd0,
    REG_MAX_HEIGHT     = 3'd1,
    REG_WIDTH_GRANULE  = 3'd2,
    REG_HEIGHT_GRANULE = 3'd3,
    REG_STRETCH        = 3'd4,
    REG_UPSCALE        = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             up;
    logic             lt;
    logic             shrinkw;
  } a_side_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] rw;
    logic [DIM_W-1:0] rh;
    logic [QW-1:0]    qa;
    logic             up;
    logic             lt;
    logic             shrinkh;
  } b_side_t;

  typedef struct packed {
    logic [GRAN_W-1:0] granule;
    logic [DIM_W-1:0]  mx;
    logic [DIM_W-1:0]  thr;
    logic              stretch_on;
  } side_cfg_t;

endpackage

`default_nettype wire

// File: sv/afss_div.sv
// ----------------------------------------------------------------------------
// afss_div
// Pipelined restoring divider, BPS quotient bits per stage, with a sideband
// word that travels alongside. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module afss_div import afss_pkg::*; #(
  parameter int NW  = 28,
  parameter int DW  = 14,
  parameter int BPS = 4,
  parameter int SW  = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [NW-1:0]      out_quo,
  output logic [SW-1:0]      out_side
);

  localparam int STAGES = (NW + BPS - 1) / BPS;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [NW-1:0] num;
    logic [DW-1:0] den;
    logic [SW-1:0] side;
  } st_t;

  st_t               st   [STAGES];
  st_t               stin [STAGES];
  st_t               stnx [STAGES];
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] vin;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign stin[s] = '{rem: '0, num: in_num, den: in_den, side: in_side};
      assign vin[s]  = in_valid;
    end else begin : g_next
      assign stin[s] = st[s-1];
      assign vin[s]  = vld[s-1];
    end

    always_comb begin
      logic [DW:0] r2;
      stnx[s] = stin[s];
      for (int k = 0; k < BPS; k++) begin
        if (s * BPS + k < NW) begin
          r2 = {stnx[s].rem, stnx[s].num[NW-1]};
          if (r2 >= {1'b0, stnx[s].den}) begin
            r2 = r2 - {1'b0, stnx[s].den};
            stnx[s].num = {stnx[s].num[NW-2:0], 1'b1};
          end else begin
            stnx[s].num = {stnx[s].num[NW-2:0], 1'b0};
          end
          stnx[s].rem = r2[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      st[s] <= stnx[s];
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= vin[s];
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_quo   = (st[STAGES-1].den == '0) ? '0 : st[STAGES-1].num;
  assign out_side  = st[STAGES-1].side;

  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, STAGES))
    else $error("divider result without an item entering");

endmodule

`default_nettype wire

// File: sv/afss_post.sv
// ----------------------------------------------------------------------------
// afss_post
// Per-side finishing: granule rounding, overshoot step-down, percent
// stretch snap and clamp at zero. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module afss_post import afss_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic signed [VW-1:0]  in_side,
  input  wire logic [DIM_W-1:0]      src,
  input  wire side_cfg_t             cfg,
  output logic                       out_valid,
  output logic [DIM_W-1:0]           out_side
);

  logic                    v1, v2, v3;
  logic signed [VW-1:0]    s1, s2;
  logic [DIM_W-1:0]        src1, src2, s3;
  logic [VW-1:0]           gmask;
  logic signed [VW-1:0]    gext, mxext, thrext, s3_next;

  assign gext   = $signed({{(VW-GRAN_W){1'b0}}, cfg.granule});
  assign gmask  = ~{{(VW-GRAN_W){1'b0}}, cfg.granule - {{(GRAN_W-1){1'b0}}, 1'b1}};
  assign mxext  = $signed({{(VW-DIM_W){1'b0}}, cfg.mx});
  assign thrext = $signed({{(VW-DIM_W){1'b0}}, cfg.thr});

  always_comb begin
    s3_next = s2;
    if (cfg.stretch_on && (s2 > thrext) && (src2 >= cfg.mx)) begin
      s3_next = mxext;
    end
    if (s3_next < 0) begin
      s3_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg.granule == '0) begin
      s1 <= in_side;
    end else begin
      s1 <= $signed(VW'(in_side + (gext >>> 1)) & gmask);
    end
    src1 <= src;
    if ((cfg.granule != '0) && (s1 > mxext)) begin
      s2 <= s1 - gext;
    end else begin
      s2 <= s1;
    end
    src2 <= src1;
    s3   <= s3_next[DIM_W-1:0];
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign out_valid = v3;
  assign out_side  = s3;

endmodule

`default_nettype wire

// File: sv/aspect_fit_scale_size.sv
// ----------------------------------------------------------------------------
// aspect_fit_scale_size
// Aspect-preserving fit of a source size into a configured maximum box.
// ----------------------------------------------------------------------------
// One item is taken in every clock: busy never rises. The result appears
// on fit_width/fit_height for one cycle with done high; the receiver cannot
// stall it. The path runs through the two chained 28-bit pipelined dividers
// (7 stages each, 4 quotient bits per stage), plus the products, selection
// and three finishing stages.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// are to be changed only while no item is in flight.
`default_nettype none

module aspect_fit_scale_size import afss_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [DIM_W-1:0] img_width,
  input  wire logic [DIM_W-1:0] img_height,
  output logic                  done,
  output logic [DIM_W-1:0]      fit_width,
  output logic [DIM_W-1:0]      fit_height,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data
);

  localparam int DIV_STAGES = (QW + DIV_BPS - 1) / DIV_BPS;
  localparam int LAT        = 3 + DIV_STAGES + 1 + DIV_STAGES + 1 + 3;

  logic [DIM_W-1:0]  max_width, max_height;
  logic [GRAN_W-1:0] width_granule, height_granule;
  logic [PCT_W-1:0]  stretch_percent;
  logic              upscale_enable;

  logic [DIM_W-1:0]  mw_sat, mh_sat, thr_w, thr_h;
  logic [PCT_W-1:0]  pct_c;
  logic [PROD_W-1:0] thr_prod_w, thr_prod_h;

  logic              v0, v1, v2, v4;
  logic [DIM_W-1:0]  w0, h0, w1, h1, w4, h4;
  logic [QW-1:0]     p1, p2, num_a, num_b;
  logic [DIM_W-1:0]  den_a, den_b;
  a_side_t           side_a;
  b_side_t           side_b, sb;
  a_side_t           sa;
  logic              va, vb, vb_in;
  logic [QW-1:0]     qa, qb;
  logic [DIM_W-1:0]  rw3, rh3;
  logic signed [VW-1:0] fw4, fh4;
  side_cfg_t         cfg_w, cfg_h;
  logic              done_h;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_width       <= 14'd640;
      max_height      <= 14'd640;
      width_granule   <= '0;
      height_granule  <= '0;
      stretch_percent <= '0;
      upscale_enable  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_WIDTH:      max_width       <= cfg_data;
        REG_MAX_HEIGHT:     max_height      <= cfg_data;
        REG_WIDTH_GRANULE:  width_granule   <= cfg_data[GRAN_W-1:0];
        REG_HEIGHT_GRANULE: height_granule  <= cfg_data[GRAN_W-1:0];
        REG_STRETCH:        stretch_percent <= cfg_data[PCT_W-1:0];
        REG_UPSCALE:        upscale_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // derived config: saturated maxima, then percent products, then thresholds, each registered
  assign pct_c = (stretch_percent > PCT_FULL) ? PCT_FULL : stretch_percent;

  always_ff @(posedge clk) begin
    mw_sat     <= (max_width > MAX_DIM) ? DIM_W'(MAX_DIM) : max_width;
    mh_sat     <= (max_height > MAX_DIM) ? DIM_W'(MAX_DIM) : max_height;
    thr_prod_w <= PROD_W'({7'b0, mw_sat} * {14'b0, PCT_FULL - pct_c});
    thr_prod_h <= PROD_W'({7'b0, mh_sat} * {14'b0, PCT_FULL - pct_c});
    thr_w      <= DIM_W'(({22'b0, thr_prod_w} * {21'b0, RECIP}) >> RECIP_SHIFT);
    thr_h      <= DIM_W'(({22'b0, thr_prod_h} * {21'b0, RECIP}) >> RECIP_SHIFT);
  end

  // input, products, divider A operand select
  always_ff @(posedge clk) begin
    w0 <= img_width;
    h0 <= img_height;
    w1 <= w0;
    h1 <= h0;
    p1 <= {{DIM_W{1'b0}}, mw_sat} * {{DIM_W{1'b0}}, h0};
    p2 <= {{DIM_W{1'b0}}, mh_sat} * {{DIM_W{1'b0}}, w0};
    side_a.w       <= w1;
    side_a.h       <= h1;
    side_a.up      <= upscale_enable;
    side_a.lt      <= p1 < p2;
    side_a.shrinkw <= w1 > mw_sat;
    if (upscale_enable && !(p1 < p2)) begin
      num_a <= p2;
      den_a <= h1;
    end else begin
      num_a <= p1;
      den_a <= w1;
    end
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= start && !busy;
      v1 <= v0;
      v2 <= v1;
    end
  end

  afss_div #(.NW(QW), .DW(DIM_W), .BPS(DIV_BPS), .SW($bits(a_side_t))) u_div_a (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_num    (num_a),
    .in_den    (den_a),
    .in_side   (side_a),
    .out_valid (va),
    .out_quo   (qa),
    .out_side  (sa)
  );

  assign rw3 = sa.shrinkw ? mw_sat : sa.w;
  assign rh3 = sa.shrinkw ? qa[DIM_W-1:0] : sa.h;

  always_ff @(posedge clk) begin
    side_b.w       <= sa.w;
    side_b.h       <= sa.h;
    side_b.rw      <= rw3;
    side_b.rh      <= rh3;
    side_b.qa      <= qa;
    side_b.up      <= sa.up;
    side_b.lt      <= sa.lt;
    side_b.shrinkh <= rh3 > mh_sat;
    num_b          <= {{DIM_W{1'b0}}, rw3} * {{DIM_W{1'b0}}, mh_sat};
    den_b          <= rh3;
    if (rst) begin
      vb_in <= 1'b0;
    end else begin
      vb_in <= va;
    end
  end

  afss_div #(.NW(QW), .DW(DIM_W), .BPS(DIV_BPS), .SW($bits(b_side_t))) u_div_b (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vb_in),
    .in_num    (num_b),
    .in_den    (den_b),
    .in_side   (side_b),
    .out_valid (vb),
    .out_quo   (qb),
    .out_side  (sb)
  );

  always_ff @(posedge clk) begin
    w4 <= sb.w;
    h4 <= sb.h;
    if (sb.up) begin
      if (sb.lt) begin
        fw4 <= $signed({{(VW-DIM_W){1'b0}}, mw_sat});
        fh4 <= $signed({2'b0, sb.qa});
      end else begin
        fw4 <= $signed({2'b0, sb.qa});
        fh4 <= $signed({{(VW-DIM_W){1'b0}}, mh_sat});
      end
    end else if (sb.shrinkh) begin
      fw4 <= $signed({2'b0, qb});
      fh4 <= $signed({{(VW-DIM_W){1'b0}}, mh_sat});
    end else begin
      fw4 <= $signed({{(VW-DIM_W){1'b0}}, sb.rw});
      fh4 <= $signed({{(VW-DIM_W){1'b0}}, sb.rh});
    end
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= vb;
    end
  end

  assign cfg_w = '{granule: width_granule, mx: mw_sat, thr: thr_w,
                   stretch_on: stretch_percent != '0};
  assign cfg_h = '{granule: height_granule, mx: mh_sat, thr: thr_h,
                   stretch_on: stretch_percent != '0};

  afss_post u_post_w (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_side   (fw4),
    .src       (w4),
    .cfg       (cfg_w),
    .out_valid (done),
    .out_side  (fit_width)
  );

  afss_post u_post_h (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_side   (fh4),
    .src       (h4),
    .cfg       (cfg_h),
    .out_valid (done_h),
    .out_side  (fit_height)
  );

  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching item");

  a_sides_aligned: assert property (@(posedge clk) done == done_h)
    else $error("width and height results out of step");

  a_width_fits: assert property (@(posedge clk) disable iff (rst)
    (done && width_granule == '0) |-> (fit_width <= mw_sat))
    else $error("unrounded width above maximum");

  a_height_fits: assert property (@(posedge clk) disable iff (rst)
    (done && height_granule == '0) |-> (fit_height <= mh_sat))
    else $error("unrounded height above maximum");

endmodule

`default_nettype wire
